// File: src/npsd_pkg.sv
`timescale 1ns / 1ps
// shared constants, operation codes and the note entry type of the note pulse driver
package npsd_pkg;

  localparam int unsigned LowestNote = 38;
  localparam int unsigned NumNotes   = 39;
  localparam int unsigned SlotW      = $clog2(NumNotes);
  localparam int unsigned NoteW      = 7;
  localparam int unsigned OpW        = 3;
  localparam int unsigned TimeW      = 16;
  localparam int unsigned CountW     = 8;
  localparam int unsigned FrameW     = 39;
  localparam logic [TimeW-1:0] OnTimeReset = TimeW'(100);

  typedef enum logic [OpW-1:0] {
    OpNoteOn  = 3'd0,
    OpNoteOff = 3'd1,
    OpStopAll = 3'd2,
    OpTick    = 3'd3,
    OpQuery   = 3'd4
  } op_e;

  typedef struct packed {
    logic [TimeW-1:0] duration;
    logic [TimeW-1:0] elapsed;
  } entry_t;

endpackage

// File: src/note_pulse_shift_driver.sv
`timescale 1ns / 1ps
// note pulse driver: per-note duration/elapsed memory, tick walker and output image
//
// One output bit per note 38..76; each word returns one result with the output
// image, a load flag and the query answer. note_on, note_off, stop_all, unused
// codes, out-of-range notes and a tick while the active count is zero finish in
// the accepting cycle. A query passes through a memory read state and a result
// state. A tick with a nonzero active count walks the note memory one entry
// per cycle through its single read port, writing each live entry back while it
// sits in the read register. A new word is taken only once the previous result
// is out or leaving the output register. Entries carry valid flops cleared by
// reset and stop_all, so no memory clearing pass exists.
module note_pulse_shift_driver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [npsd_pkg::TimeW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [npsd_pkg::OpW-1:0]      operation_i,
  input  logic [npsd_pkg::NoteW-1:0]    note_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [npsd_pkg::FrameW-1:0]   frame_o,
  output logic                          load_pulse_o,
  output logic                          note_active_o
);
  import npsd_pkg::*;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StQuery  = 4'b0010,
    StTick   = 4'b0100,
    StResult = 4'b1000
  } state_e;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(NumNotes - 1);

  state_e state_q, state_d;
  logic [TimeW-1:0]    on_time_q;
  logic [NumNotes-1:0] bits_q, bits_d;
  logic [NumNotes-1:0] valid_q, valid_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [SlotW-1:0]    idx_q, idx_d;
  logic                expired_q, expired_d;
  logic                answer_q, answer_d;
  logic                out_valid_q, out_valid_d;
  logic [FrameW-1:0]   frame_q, frame_d;
  logic                load_q, load_d;
  logic                active_q, active_d;

  entry_t              note_mem_q [NumNotes];
  entry_t              rdata_q;
  entry_t              entry;
  logic                mem_we;
  logic [SlotW-1:0]    mem_waddr, mem_raddr;
  entry_t              mem_wdata;

  logic                out_free, accept, in_range, respond, resp_load;
  logic [SlotW-1:0]    slot, idx_next;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = note_i inside {[NoteW'(LowestNote) : NoteW'(LowestNote + NumNotes - 1)]};
  assign slot       = SlotW'(note_i - NoteW'(LowestNote));
  assign idx_next   = (idx_q == LastSlot) ? '0 : SlotW'(idx_q + 1'b1);
  // an entry never written since reset or stop_all reads as zero
  assign entry      = valid_q[idx_q] ? rdata_q : '0;

  always_comb begin
    state_d     = state_q;
    bits_d      = bits_q;
    valid_d     = valid_q;
    count_d     = count_q;
    idx_d       = idx_q;
    expired_d   = expired_q;
    answer_d    = answer_q;
    out_valid_d = out_valid_q && !out_ready_i;
    frame_d     = frame_q;
    load_d      = load_q;
    active_d    = active_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;
    mem_raddr   = idx_next;
    respond     = 1'b0;
    resp_load   = 1'b0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          respond = 1'b1;
          case (op_e'(operation_i))
            OpNoteOn: begin
              if (in_range) begin
                mem_we        = 1'b1;
                mem_waddr     = slot;
                mem_wdata     = '{duration: on_time_q, elapsed: '0};
                valid_d[slot] = 1'b1;
                bits_d[slot]  = 1'b1;
                count_d       = CountW'(count_q + 1'b1);
                resp_load     = 1'b1;
              end
            end
            OpNoteOff: begin
              if (in_range && bits_q[slot]) begin
                valid_d[slot] = 1'b0;
                bits_d[slot]  = 1'b0;
                count_d       = CountW'(count_q - 1'b1);
                resp_load     = 1'b1;
              end
            end
            OpStopAll: begin
              valid_d   = '0;
              bits_d    = '0;
              count_d   = '0;
              resp_load = 1'b1;
            end
            OpTick: begin
              if (count_q != '0) begin
                respond   = 1'b0;
                mem_raddr = '0;
                idx_d     = '0;
                expired_d = 1'b0;
                state_d   = StTick;
              end
            end
            OpQuery: begin
              if (in_range) begin
                respond   = 1'b0;
                mem_raddr = slot;
                idx_d     = slot;
                state_d   = StQuery;
              end
            end
            default: begin
            end
          endcase
          if (respond) begin
            out_valid_d = 1'b1;
            frame_d     = FrameW'(bits_d);
            load_d      = resp_load;
            active_d    = 1'b0;
          end
        end
      end
      StQuery: begin
        answer_d  = (entry.duration != '0);
        expired_d = 1'b0;
        state_d   = StResult;
      end
      StTick: begin
        // entry idx_q is in the read register; its write-back never meets the next read
        if (entry.duration != '0) begin
          mem_we = 1'b1;
          if (entry.elapsed >= entry.duration) begin
            valid_d[idx_q] = 1'b0;
            bits_d[idx_q]  = 1'b0;
            expired_d      = 1'b1;
          end else begin
            mem_wdata = '{duration: entry.duration,
                          elapsed: TimeW'(entry.elapsed + 1'b1)};
          end
        end
        idx_d = idx_next;
        if (idx_q == LastSlot) begin
          answer_d = 1'b0;
          state_d  = StResult;
        end
      end
      StResult: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          frame_d     = FrameW'(bits_q);
          load_d      = expired_q;
          active_d    = answer_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      note_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= note_mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      on_time_q   <= OnTimeReset;
      bits_q      <= '0;
      valid_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      expired_q   <= 1'b0;
      answer_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        on_time_q <= cfg_wdata_i;
      end
      bits_q      <= bits_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      expired_q   <= expired_d;
      answer_q    <= answer_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q  <= frame_d;
    load_q   <= load_d;
    active_q <= active_d;
  end

  assign out_valid_o   = out_valid_q;
  assign frame_o       = frame_q;
  assign load_pulse_o  = load_q;
  assign note_active_o = active_q;

endmodule

// File: dv/tb_note_pulse_shift_driver.sv
`timescale 1ns / 1ps
// testbench for note_pulse_shift_driver: random and directed note words checked against a predictor
module tb_note_pulse_shift_driver;
  import npsd_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned MaxPrinted = 40;
  localparam logic [OpW-1:0] FirstUnusedOp = 3'd5;
  localparam logic [OpW-1:0] LastUnusedOp = 3'd7;
  localparam int unsigned TopNote = LowestNote + NumNotes - 1;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [NoteW-1:0] note;
  } note_word_t;

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic              load;
    logic              active;
  } note_image_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [TimeW-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [OpW-1:0]      operation_i = '0;
  logic [NoteW-1:0]    note_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [FrameW-1:0]   frame_o;
  logic                load_pulse_o;
  logic                note_active_o;

  note_pulse_shift_driver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .note_i        (note_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_o       (frame_o),
    .load_pulse_o  (load_pulse_o),
    .note_active_o (note_active_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predicted note state
  logic [TimeW-1:0]  note_len [NumNotes];
  logic [TimeW-1:0]  note_age [NumNotes];
  logic [NumNotes-1:0] lit_notes = '0;
  logic [CountW-1:0] held_count = '0;
  logic [TimeW-1:0]  pulse_len = OnTimeReset;

  note_word_t  words_to_send [$];
  note_image_t images_due [$];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned holdoff_left = 0;
  bit          holdoff_arm = 1'b0;
  logic        word_taken = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned words_sent = 0;
  int unsigned images_checked = 0;
  int unsigned loads_seen = 0;
  int unsigned walks_done = 0;
  int unsigned expiries = 0;

  initial begin
    for (int i = 0; i < NumNotes; i++) begin
      note_len[i] = '0;
      note_age[i] = '0;
    end
  end

  function automatic note_image_t apply_word(note_word_t w);
    note_image_t r;
    bit          in_range;
    int          slot;
    r = '0;
    in_range = (w.note >= LowestNote) && (w.note <= TopNote);
    slot = int'(w.note) - int'(LowestNote);
    case (w.op)
      OpNoteOn: begin
        if (in_range) begin
          note_len[slot] = pulse_len;
          note_age[slot] = '0;
          lit_notes[slot] = 1'b1;
          held_count = held_count + 1'b1;
          r.load = 1'b1;
        end
      end
      OpNoteOff: begin
        if (in_range && lit_notes[slot]) begin
          note_len[slot] = '0;
          note_age[slot] = '0;
          lit_notes[slot] = 1'b0;
          held_count = held_count - 1'b1;
          r.load = 1'b1;
        end
      end
      OpStopAll: begin
        for (int i = 0; i < NumNotes; i++) begin
          note_len[i] = '0;
          note_age[i] = '0;
        end
        lit_notes = '0;
        held_count = '0;
        r.load = 1'b1;
      end
      OpTick: begin
        if (held_count != 0) begin
          walks_done++;
          for (int i = 0; i < NumNotes; i++) begin
            if (note_len[i] != 0) begin
              if (note_age[i] >= note_len[i]) begin
                note_len[i] = '0;
                note_age[i] = '0;
                lit_notes[i] = 1'b0;
                r.load = 1'b1;
                expiries++;
              end else begin
                note_age[i] = note_age[i] + 1'b1;
              end
            end
          end
        end
      end
      OpQuery: begin
        if (in_range) r.active = (note_len[slot] != 0);
      end
      default: ;
    endcase
    r.frame = FrameW'(lit_notes);
    return r;
  endfunction

  function automatic note_word_t random_word();
    note_word_t  w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) w.op = OpNoteOn;
    else if (pick < 50) w.op = OpNoteOff;
    else if (pick < 78) w.op = OpTick;
    else if (pick < 92) w.op = OpQuery;
    else if (pick < 95) w.op = OpStopAll;
    else w.op = OpW'($urandom_range(FirstUnusedOp, LastUnusedOp));
    // mostly playable notes, some from the whole range
    if ($urandom_range(9) == 0) w.note = NoteW'($urandom_range(127));
    else w.note = NoteW'($urandom_range(LowestNote, TopNote));
    return w;
  endfunction

  task automatic queue_word(input logic [OpW-1:0] op, input int unsigned note);
    words_to_send.push_back({op, NoteW'(note)});
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] seen);
    if (error_count < MaxPrinted)
      $display("mismatch on %s at result %0d: expected %h, got %h",
               field, images_checked, want, seen);
    error_count++;
  endtask

  task automatic wait_idle();
    while (!(words_to_send.size() == 0 && !in_valid_i && images_due.size() == 0))
      @(posedge clk_i);
  endtask

  task automatic write_on_time(input logic [TimeW-1:0] len);
    wait_idle();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    pulse_len = len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [TimeW-1:0] len, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned count,
                           input bit squeeze);
    write_on_time(len);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) words_to_send.push_back(random_word());
    if (squeeze) begin
      holdoff_arm = 1'b1;
      while (holdoff_left == 0) @(posedge clk_i);
      holdoff_arm = 1'b0;
    end
    wait_idle();
  endtask

  // word driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !word_taken) begin
      in_valid_i <= 1'b1;
    end else if (words_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
      note_word_t w;
      w = words_to_send.pop_front();
      operation_i <= w.op;
      note_i <= w.note;
      in_valid_i <= 1'b1;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // long receiver hold-off, counted on its own
  always @(negedge clk_i) begin
    if (holdoff_left != 0) holdoff_left <= holdoff_left - 1;
    else if (holdoff_arm) holdoff_left <= HoldOffCycles;
  end

  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && (holdoff_left == 0) &&
                   ($urandom_range(99) >= receiver_stall_pct);
  end

  // result check first, then prediction of any word taken at this edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (images_due.size() == 0) begin
          report_mismatch("unexpected result", '0, 64'(frame_o));
        end else begin
          note_image_t want;
          want = images_due.pop_front();
          if (frame_o !== want.frame)
            report_mismatch("frame", 64'(want.frame), 64'(frame_o));
          if (load_pulse_o !== want.load)
            report_mismatch("load_pulse", 64'(want.load), 64'(load_pulse_o));
          if (note_active_o !== want.active)
            report_mismatch("note_active", 64'(want.active), 64'(note_active_o));
        end
        if (load_pulse_o) loads_seen++;
        images_checked++;
      end
      word_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        images_due.push_back(apply_word({operation_i, note_i}));
        words_sent++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[note_pulse_shift_driver] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset duration: edges of the note range, repeats, out-of-range and unused codes
    queue_word(OpTick, LowestNote);
    queue_word(OpQuery, LowestNote);
    queue_word(OpNoteOn, LowestNote);
    queue_word(OpNoteOn, TopNote);
    queue_word(OpNoteOn, LowestNote - 1);
    queue_word(OpNoteOn, TopNote + 1);
    queue_word(OpNoteOn, 127);
    queue_word(OpNoteOn, LowestNote);
    queue_word(OpQuery, LowestNote);
    queue_word(OpQuery, TopNote + 1);
    queue_word(OpTick, 0);
    queue_word(OpNoteOff, TopNote);
    queue_word(OpNoteOff, TopNote);
    queue_word(OpNoteOff, LowestNote - 1);
    for (int c = FirstUnusedOp; c <= LastUnusedOp; c++) queue_word(OpW'(c), LowestNote);
    queue_word(OpStopAll, 0);
    queue_word(OpTick, 0);

    // one-tick duration: two notes expire in the same tick
    write_on_time(16'd1);
    queue_word(OpNoteOn, 50);
    queue_word(OpNoteOn, 51);
    queue_word(OpTick, 0);
    queue_word(OpTick, 0);
    queue_word(OpQuery, 50);

    // wrap the 8-bit active count back to zero with notes still lit
    write_on_time(16'd0);
    queue_word(OpStopAll, 0);
    queue_word(OpNoteOn, LowestNote);
    for (int i = 1; i < 256; i++) queue_word(OpNoteOn, $urandom_range(LowestNote, TopNote));
    queue_word(OpTick, 0);
    queue_word(OpNoteOff, LowestNote);
    queue_word(OpTick, 0);

    run_phase(16'hFFFF, 0, 0, 160, 1'b0);
    run_phase(16'd3, 69, 0, 160, 1'b0);
    run_phase(16'd0, 0, 69, 160, 1'b0);
    run_phase(16'd2, 27, 27, 160, 1'b1);
    run_phase(TimeW'($urandom_range(1, 12)), 0, 0, 160, 1'b0);
    run_phase(16'd5, 69, 0, 160, 1'b0);
    run_phase(TimeW'($urandom_range(13, 60)), 0, 69, 160, 1'b0);

    wait_idle();
    repeat (60) @(posedge clk_i);
    $display("sent %0d words, checked %0d results, %0d loads", words_sent, images_checked,
             loads_seen);
    $display("%0d tick walks with %0d note expiries, %0d mismatches", walks_done, expiries,
             error_count);
    if (error_count == 0 && images_due.size() == 0) begin
      $display("[note_pulse_shift_driver] OK");
    end else begin
      $display("[note_pulse_shift_driver] ERROR");
    end
    $finish;
  end

endmodule
